/* hdl/hmac_md5_engine_top_assert.svh */
// Assertion macros shared by the HMAC-MD5 engine modules.
`ifndef HMAC_MD5_ENGINE_TOP_ASSERT_SVH
`define HMAC_MD5_ENGINE_TOP_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define HM_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequence is checked in the cycle after the antecedent.
`define HM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/hmac_pkg.sv */
// Package with the MD5 constant tables and helper functions of the HMAC-MD5 engine.
`timescale 1ns / 1ps
`default_nettype none
package hmac_pkg;
    localparam int unsigned BLOCK_BYTES  = 64;
    localparam int unsigned DIGEST_BYTES = 16;
    localparam logic [7:0]  IPAD_BYTE    = 8'h36;
    localparam logic [7:0]  OPAD_BYTE    = 8'h5c;
    localparam logic        MODE_KEY     = 1'b0;
    localparam logic        MODE_MSG     = 1'b1;

    typedef logic [31:0] word_t;
    typedef logic [7:0]  byte_t;

    localparam word_t IV_A = 32'h67452301;
    localparam word_t IV_B = 32'hefcdab89;
    localparam word_t IV_C = 32'h98badcfe;
    localparam word_t IV_D = 32'h10325476;

    function automatic word_t sine_const(input logic [5:0] i);
        word_t r;
        case (i)
            6'd0:  r = 32'hd76aa478; 6'd1:  r = 32'he8c7b756;
            6'd2:  r = 32'h242070db; 6'd3:  r = 32'hc1bdceee;
            6'd4:  r = 32'hf57c0faf; 6'd5:  r = 32'h4787c62a;
            6'd6:  r = 32'ha8304613; 6'd7:  r = 32'hfd469501;
            6'd8:  r = 32'h698098d8; 6'd9:  r = 32'h8b44f7af;
            6'd10: r = 32'hffff5bb1; 6'd11: r = 32'h895cd7be;
            6'd12: r = 32'h6b901122; 6'd13: r = 32'hfd987193;
            6'd14: r = 32'ha679438e; 6'd15: r = 32'h49b40821;
            6'd16: r = 32'hf61e2562; 6'd17: r = 32'hc040b340;
            6'd18: r = 32'h265e5a51; 6'd19: r = 32'he9b6c7aa;
            6'd20: r = 32'hd62f105d; 6'd21: r = 32'h02441453;
            6'd22: r = 32'hd8a1e681; 6'd23: r = 32'he7d3fbc8;
            6'd24: r = 32'h21e1cde6; 6'd25: r = 32'hc33707d6;
            6'd26: r = 32'hf4d50d87; 6'd27: r = 32'h455a14ed;
            6'd28: r = 32'ha9e3e905; 6'd29: r = 32'hfcefa3f8;
            6'd30: r = 32'h676f02d9; 6'd31: r = 32'h8d2a4c8a;
            6'd32: r = 32'hfffa3942; 6'd33: r = 32'h8771f681;
            6'd34: r = 32'h6d9d6122; 6'd35: r = 32'hfde5380c;
            6'd36: r = 32'ha4beea44; 6'd37: r = 32'h4bdecfa9;
            6'd38: r = 32'hf6bb4b60; 6'd39: r = 32'hbebfbc70;
            6'd40: r = 32'h289b7ec6; 6'd41: r = 32'heaa127fa;
            6'd42: r = 32'hd4ef3085; 6'd43: r = 32'h04881d05;
            6'd44: r = 32'hd9d4d039; 6'd45: r = 32'he6db99e5;
            6'd46: r = 32'h1fa27cf8; 6'd47: r = 32'hc4ac5665;
            6'd48: r = 32'hf4292244; 6'd49: r = 32'h432aff97;
            6'd50: r = 32'hab9423a7; 6'd51: r = 32'hfc93a039;
            6'd52: r = 32'h655b59c3; 6'd53: r = 32'h8f0ccc92;
            6'd54: r = 32'hffeff47d; 6'd55: r = 32'h85845dd1;
            6'd56: r = 32'h6fa87e4f; 6'd57: r = 32'hfe2ce6e0;
            6'd58: r = 32'ha3014314; 6'd59: r = 32'h4e0811a1;
            6'd60: r = 32'hf7537e82; 6'd61: r = 32'hbd3af235;
            6'd62: r = 32'h2ad7d2bb; default: r = 32'heb86d391;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] rot_amount(input logic [5:0] i);
        logic [4:0] r;
        case ({i[5:4], i[1:0]})
            4'd0:  r = 5'd7;  4'd1:  r = 5'd12; 4'd2:  r = 5'd17; 4'd3:  r = 5'd22;
            4'd4:  r = 5'd5;  4'd5:  r = 5'd9;  4'd6:  r = 5'd14; 4'd7:  r = 5'd20;
            4'd8:  r = 5'd4;  4'd9:  r = 5'd11; 4'd10: r = 5'd16; 4'd11: r = 5'd23;
            4'd12: r = 5'd6;  4'd13: r = 5'd10; 4'd14: r = 5'd15; default: r = 5'd21;
        endcase
        return r;
    endfunction

    // Message word used by round i.
    function automatic logic [3:0] word_index(input logic [5:0] i);
        logic [3:0] r;
        case (i[5:4])
            2'd0:    r = i[3:0];
            2'd1:    r = 4'(5 * i[3:0] + 1);
            2'd2:    r = 4'(3 * i[3:0] + 5);
            default: r = 4'(7 * i[3:0]);
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

/* hdl/hmac_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module hmac_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* hdl/hmac_core.sv */
// MD5 compression unit: absorbs one block byte by byte, packed into words in a RAM, then runs 64 rounds.
`timescale 1ns / 1ps
`default_nettype none
module hmac_core (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                init,      // restart chain and length
    input  wire logic                byte_vld,  // absorb one byte (count it)
    input  wire logic                pad_vld,   // write one padding byte (not counted)
    input  wire hmac_pkg::byte_t     byte_in,
    input  wire logic                run,       // compress buffered block
    output logic                     busy,
    output logic [5:0]               pos,       // byte position within the block
    output logic [63:0]              length,
    output hmac_pkg::word_t          chain [4]
);
    import hmac_pkg::*;

    logic         we;
    logic [3:0]   waddr, raddr;
    word_t        wdata, rdata;
    word_t        acc_reg, acc_next;
    logic [63:0]  len_reg;
    logic [5:0]   wpos_reg;
    word_t        a_reg, b_reg, c_reg, d_reg;
    word_t        h_reg [4];
    logic [6:0]   rnd_reg;
    logic         busy_reg, fin_reg;
    word_t        f, sum;
    logic [5:0]   rnd;
    logic         wr_byte;

    assign wr_byte = byte_vld || pad_vld;
    assign pos     = wpos_reg;
    assign length  = len_reg;
    // The fold cycle counts as busy, so the chain is final once busy drops.
    assign busy    = busy_reg || fin_reg;
    assign chain   = h_reg;
    assign rnd     = rnd_reg[5:0];

    // Bytes collect little-endian into a word; the word goes to RAM on its fourth byte.
    always_comb begin
        acc_next = acc_reg;
        case (wpos_reg[1:0])
            2'd0:    acc_next[7:0]   = byte_in;
            2'd1:    acc_next[15:8]  = byte_in;
            2'd2:    acc_next[23:16] = byte_in;
            default: acc_next[31:24] = byte_in;
        endcase
    end
    assign we    = wr_byte && (wpos_reg[1:0] == 2'd3);
    assign waddr = wpos_reg[5:2];
    assign wdata = acc_next;
    // Address for the next round is presented during the current one, to suit the registered read port.
    assign raddr = busy_reg ? word_index(6'(rnd_reg + 7'd1)) : word_index(6'd0);

    hmac_ram #(.WIDTH(32), .DEPTH(16)) u_wram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    always_comb begin
        case (rnd[5:4])
            2'd0:    f = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1:    f = (b_reg & d_reg) | (c_reg & ~d_reg);
            2'd2:    f = b_reg ^ c_reg ^ d_reg;
            default: f = c_reg ^ (b_reg | ~d_reg);
        endcase
        sum = a_reg + f + sine_const(rnd) + rdata;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || init) begin
            h_reg    <= '{IV_A, IV_B, IV_C, IV_D};
            len_reg  <= '0;
            wpos_reg <= '0;
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            rnd_reg  <= '0;
        end else begin
            if (wr_byte) begin
                acc_reg  <= acc_next;
                wpos_reg <= wpos_reg + 6'd1;
            end
            if (byte_vld) begin
                len_reg <= len_reg + 64'd1;
            end
            fin_reg <= 1'b0;
            if (run && !busy_reg) begin
                busy_reg <= 1'b1;
                rnd_reg  <= '0;
                {a_reg, b_reg, c_reg, d_reg} <= {h_reg[0], h_reg[1], h_reg[2], h_reg[3]};
            end else if (busy_reg) begin
                a_reg <= d_reg;
                d_reg <= c_reg;
                c_reg <= b_reg;
                b_reg <= b_reg + ((sum << rot_amount(rnd)) | (sum >> (6'd32 - rot_amount(rnd))));
                rnd_reg <= rnd_reg + 7'd1;
                if (rnd_reg == 7'd63) begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            if (fin_reg) begin
                h_reg[0] <= h_reg[0] + a_reg;
                h_reg[1] <= h_reg[1] + b_reg;
                h_reg[2] <= h_reg[2] + c_reg;
                h_reg[3] <= h_reg[3] + d_reg;
            end
        end
    end

    `include "hmac_md5_engine_top_assert.svh"
    `HM_ASSERT_NEXT(a_round_end, aclk, aresetn, busy_reg && rnd_reg == 7'd63 && !init, fin_reg, "fold missing")
    `HM_ASSERT_IMP(a_no_write_busy, aclk, aresetn, busy_reg, !wr_byte, "block written during rounds")
    `HM_ASSERT_IMP(a_round_range, aclk, aresetn, busy_reg, !rnd_reg[6], "round count overflow")
endmodule
`default_nettype wire

/* hdl/hmac_md5_engine_top.sv */
// Top level of the HMAC-MD5 engine: key handling, padding sequencer and digest output.
//  channel | direction | words
//  s_axis  | in        | key or message byte per word unless no_byte, tlast ends a segment
//  m_axis  | out       | 16 digest bytes, tlast on the last
// Data bytes enter while the input is ready; every 64th counted byte starts the rounds.
// A key longer than 64 bytes is first hashed by replaying its stored bytes into the core.
// Ending a key starts the inner key hashing, after a key digest for a hashed key.
// The end of the message is followed by padding and the outer hashing.
// Key block memory clears by a sweep of its 64 addresses after reset and after each digest.
// Input stalls while the compression unit or the sequencer is busy.
`timescale 1ns / 1ps
`default_nettype none
module hmac_md5_engine_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // value_byte
    input  wire logic [1:0]  s_axis_tuser,   // mode, no_byte
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // digest_byte
    output logic             m_axis_tlast
);
    import hmac_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_WAIT, S_REPLAY, S_PAD, S_LEN, S_FIN,
        S_KCOPY, S_IPAD, S_OUT_PAD, S_OUT_DIG, S_OUT
    } state_t;

    state_t       state_reg;
    logic         phase_reg, hashed_reg;
    logic [6:0]   kcnt_reg;
    logic [6:0]   cnt_reg;         // sweep and byte counter of the sequencer states
    logic [1:0]   fin_reg;         // 0 key digest, 1 inner, 2 outer
    logic [63:0]  bits_reg;
    byte_t        idig_reg [DIGEST_BYTES];
    byte_t        odig_reg [DIGEST_BYTES];
    logic [3:0]   ocnt_reg;
    logic         fed_reg;         // key ram read in flight during replay and the key pad passes
    logic         pend_last_reg;

    logic         init, bvld, pvld, run, cbusy;
    byte_t        cbyte;
    logic [5:0]   cpos;
    logic [63:0]  clen;
    word_t        chain [4];

    logic         k_we;
    logic [5:0]   k_waddr, k_raddr;
    byte_t        k_wdata, k_rdata;

    logic         acc, item_ok, has_byte;

    hmac_ram #(.WIDTH(8), .DEPTH(BLOCK_BYTES)) u_kram (
        .aclk(aclk), .we(k_we), .waddr(k_waddr), .wdata(k_wdata),
        .raddr(k_raddr), .rdata(k_rdata)
    );

    hmac_core u_core (
        .aclk(aclk), .aresetn(aresetn), .init(init), .byte_vld(bvld), .pad_vld(pvld),
        .byte_in(cbyte), .run(run), .busy(cbusy), .pos(cpos), .length(clen), .chain(chain)
    );

    assign s_axis_tready = (state_reg == S_IDLE) && !cbusy;
    assign acc      = s_axis_tvalid && s_axis_tready;
    assign has_byte = !s_axis_tuser[1];
    assign item_ok  = acc && (s_axis_tuser[0] == phase_reg) && (has_byte || s_axis_tlast);
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata  = odig_reg[ocnt_reg];
    assign m_axis_tlast  = (ocnt_reg == 4'(DIGEST_BYTES - 1));
    assign k_raddr  = cnt_reg[5:0];

    // Data path to the core and key memory, decided from the current state.
    always_comb begin
        init = 1'b0; bvld = 1'b0; pvld = 1'b0; cbyte = s_axis_tdata;
        k_we = 1'b0; k_waddr = kcnt_reg[5:0]; k_wdata = s_axis_tdata;
        case (state_reg)
            S_CLEAR: begin
                k_we = 1'b1; k_waddr = cnt_reg[5:0]; k_wdata = '0; init = 1'b1;
            end
            S_IDLE: begin
                if (item_ok && has_byte) begin
                    if (phase_reg == MODE_MSG || hashed_reg) begin
                        bvld = 1'b1;
                    end else if (!kcnt_reg[6]) begin
                        k_we = 1'b1;
                    end else begin
                        init = 1'b1;
                    end
                end
            end
            S_REPLAY: begin
                bvld = fed_reg && !cbusy;
                cbyte = cnt_reg == 7'd64 ? idig_reg[0] : k_rdata;
            end
            S_PAD: begin
                pvld = !cbusy; cbyte = cnt_reg == 7'd0 ? 8'h80 : 8'h00;
            end
            S_LEN: begin
                pvld = 1'b1; cbyte = bits_reg[8 * cnt_reg[2:0] +: 8];
            end
            S_FIN: begin
                // The outer pass starts from a fresh chain once the inner digest is taken.
                init = !cbusy && fin_reg == 2'd1;
            end
            S_KCOPY: begin
                k_we = 1'b1; k_waddr = cnt_reg[5:0];
                k_wdata = cnt_reg[6:4] == 3'd0 ? chain[cnt_reg[3:2]][8 * cnt_reg[1:0] +: 8] : 8'h00;
                init = cnt_reg == 7'd63;
            end
            S_IPAD: begin
                bvld = fed_reg && !cbusy; cbyte = k_rdata ^ IPAD_BYTE;
            end
            S_OUT_PAD: begin
                bvld = fed_reg && !cbusy; cbyte = k_rdata ^ OPAD_BYTE;
            end
            S_OUT_DIG: begin
                bvld = !cbusy; cbyte = idig_reg[cnt_reg[3:0]];
            end
            default: begin
            end
        endcase
    end
    assign run = bvld && !cbusy && (cpos == 6'd63) || (pvld && cpos == 6'd63);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_CLEAR;
            cnt_reg    <= '0;
            phase_reg  <= MODE_KEY;
            hashed_reg <= 1'b0;
            kcnt_reg   <= '0;
            fed_reg    <= 1'b0;
            ocnt_reg   <= '0;
            fin_reg    <= '0;
            pend_last_reg <= 1'b0;
        end else begin
            case (state_reg)
                S_CLEAR: begin
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg == 7'd63) begin
                        state_reg <= S_IDLE; cnt_reg <= '0;
                        phase_reg <= MODE_KEY; hashed_reg <= 1'b0; kcnt_reg <= '0;
                    end
                end
                S_IDLE: begin
                    if (item_ok) begin
                        pend_last_reg <= s_axis_tlast;
                        if (has_byte && phase_reg == MODE_KEY && !hashed_reg
                            && !kcnt_reg[6]) begin
                            kcnt_reg <= kcnt_reg + 7'd1;
                        end
                        if (has_byte && phase_reg == MODE_KEY && !hashed_reg && kcnt_reg[6]) begin
                            // Replay the 64 stored key bytes, then this one.
                            state_reg <= S_REPLAY; cnt_reg <= '0; fed_reg <= 1'b0;
                            hashed_reg <= 1'b1;
                            idig_reg[0] <= s_axis_tdata;
                        end else if (s_axis_tlast) begin
                            state_reg <= S_WAIT;
                        end
                    end
                end
                S_WAIT: begin
                    // Let any compression kicked off by the last byte settle.
                    if (!cbusy && !run) begin
                        if (phase_reg == MODE_KEY && !hashed_reg) begin
                            state_reg <= S_IPAD; cnt_reg <= '0; fed_reg <= 1'b0;
                        end else begin
                            fin_reg   <= phase_reg == MODE_KEY ? 2'd0 : 2'd1;
                            bits_reg  <= {clen[60:0], 3'b000};
                            state_reg <= S_PAD; cnt_reg <= '0;
                        end
                    end
                end
                S_REPLAY: begin
                    if (!fed_reg) begin
                        fed_reg <= 1'b1;
                    end else if (!cbusy) begin
                        cnt_reg <= cnt_reg + 7'd1;
                        fed_reg <= 1'b0;
                        if (cnt_reg == 7'd64) begin
                            state_reg <= pend_last_reg ? S_WAIT : S_IDLE;
                        end
                    end
                end
                S_PAD: begin
                    if (!cbusy) begin
                        cnt_reg <= cnt_reg + 7'd1;
                        if (cpos == 6'd55) begin
                            state_reg <= S_LEN; cnt_reg <= '0;
                        end
                    end
                end
                S_LEN: begin
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg == 7'd7) begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!cbusy) begin
                        cnt_reg <= '0; fed_reg <= 1'b0;
                        case (fin_reg)
                            2'd0: state_reg <= S_KCOPY;
                            2'd1: begin
                                for (int i = 0; i < DIGEST_BYTES; i++) begin
                                    idig_reg[i] <= chain[i / 4][8 * (i % 4) +: 8];
                                end
                                state_reg <= S_OUT_PAD;
                            end
                            default: begin
                                for (int i = 0; i < DIGEST_BYTES; i++) begin
                                    odig_reg[i] <= chain[i / 4][8 * (i % 4) +: 8];
                                end
                                state_reg <= S_OUT; ocnt_reg <= '0;
                            end
                        endcase
                    end
                end
                S_KCOPY: begin
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg == 7'd63) begin
                        state_reg <= S_IPAD; cnt_reg <= '0;
                    end
                end
                S_IPAD, S_OUT_PAD: begin
                    if (!fed_reg) begin
                        fed_reg <= 1'b1;
                    end else if (!cbusy) begin
                        cnt_reg <= cnt_reg + 7'd1;
                        fed_reg <= 1'b0;
                        if (cnt_reg == 7'd63) begin
                            cnt_reg <= '0;
                            if (state_reg == S_IPAD) begin
                                state_reg <= S_IDLE; phase_reg <= MODE_MSG;
                            end else begin
                                state_reg <= S_OUT_DIG;
                            end
                        end
                    end
                end
                S_OUT_DIG: begin
                    if (!cbusy && !run) begin
                        cnt_reg <= cnt_reg + 7'd1;
                        if (cnt_reg == 7'd15) begin
                            fin_reg <= 2'd2; bits_reg <= 64'd640;
                            state_reg <= S_PAD; cnt_reg <= '0;
                        end
                    end
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        ocnt_reg <= ocnt_reg + 4'd1;
                        if (m_axis_tlast) begin
                            state_reg <= S_CLEAR; cnt_reg <= '0;
                        end
                    end
                end
                default: state_reg <= S_CLEAR;
            endcase
        end
    end

    // The core must restart when the outer pass begins; done via init in FIN->OUT_PAD.
    `include "hmac_md5_engine_top_assert.svh"
    `HM_ASSERT_IMP(a_out_only, aclk, aresetn, m_axis_tvalid, !s_axis_tready, "input open during output")
    `HM_ASSERT_IMP(a_key_cnt, aclk, aresetn, hashed_reg, kcnt_reg == 7'd64, "hashed key short")
    `HM_ASSERT_NEXT(a_out_done, aclk, aresetn, m_axis_tvalid && m_axis_tready && m_axis_tlast, state_reg == S_CLEAR, "no clear after digest")
endmodule
`default_nettype wire
